// ----- design/css_pkg.sv -----
package css_pkg;

    localparam int DEF_MAX_ROWS  = 65536;
    localparam int DEF_FRAC_BITS = 12;

    localparam int VAL_W   = 24;
    localparam int SD_W    = 23;
    localparam int SUM_W   = 41;
    localparam int SQ_W    = 64;
    localparam int CNT_W   = 17;
    localparam int WIDE_W  = 82;
    localparam int DVS_W   = 32;
    localparam int ROOT_W  = 32;
    localparam int STEP_W  = 7;
    localparam int IDX_W   = 2;

    localparam logic [STEP_W-1:0] MUL_STEPS  = 7'd41;
    localparam logic [STEP_W-1:0] DIV_STEPS  = 7'd82;
    localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd32;

    localparam logic [IDX_W-1:0] REG_SPARSE_MODE = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW_COUNT   = 2'd1;

    typedef enum logic [2:0] {
        OP_MUL_A    = 3'd0,
        OP_MUL_B    = 3'd1,
        OP_MUL_D    = 3'd2,
        OP_DIV_MEAN = 3'd3,
        OP_DIV_VAR  = 3'd4,
        OP_SQRT     = 3'd5
    } op_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        op_t  op;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

// ----- design/css_ctrl.sv -----
module css_ctrl import css_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  logic    s_tlast,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_MUL_A    = 8'b0000_0010,
        ST_MUL_B    = 8'b0000_0100,
        ST_MUL_D    = 8'b0000_1000,
        ST_DIV_MEAN = 8'b0001_0000,
        ST_DIV_VAR  = 8'b0010_0000,
        ST_SQRT     = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [STEP_W-1:0] steps;
    state_t            follow;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        steps  = MUL_STEPS;
        follow = ST_IDLE;
        cmd.op = OP_MUL_A;
        case (state_reg)
            ST_MUL_A: begin
                cmd.op = OP_MUL_A;    steps = MUL_STEPS;  follow = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.op = OP_MUL_B;    steps = MUL_STEPS;  follow = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.op = OP_MUL_D;    steps = MUL_STEPS;  follow = ST_DIV_MEAN;
            end
            ST_DIV_MEAN: begin
                cmd.op = OP_DIV_MEAN; steps = DIV_STEPS;  follow = ST_DIV_VAR;
            end
            ST_DIV_VAR: begin
                cmd.op = OP_DIV_VAR;  steps = DIV_STEPS;  follow = ST_SQRT;
            end
            ST_SQRT: begin
                cmd.op = OP_SQRT;     steps = SQRT_STEPS; follow = ST_OUT;
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.accept   = 1'b0;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_MUL_A;
                    cnt_next   = '0;
                end
            end
            ST_OUT: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                // first cycle loads operands, then one step per cycle
                if (cnt_reg == '0) begin
                    cmd.load = 1'b1;
                end else begin
                    cmd.step = 1'b1;
                end
                if (cnt_reg == steps) begin
                    state_next = follow;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- design/css_dpath.sv -----
module css_dpath import css_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    cmd,
    output status_t                 status,
    input  logic signed [VAL_W-1:0] sample_value,
    input  logic                    is_missing,
    input  logic                    last_in_column,
    input  logic                    cfg_valid,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CNT_W-1:0]        cfg_data,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [47:0]             m_tdata,
    output logic                    m_tuser
);

    localparam logic [CNT_W-1:0] MAX_N   = CNT_W'(MAX_ROWS);
    localparam logic [SD_W-1:0]  SD_ONE  = SD_W'(1) << FRAC_BITS;
    localparam logic [SD_W-1:0]  SD_MAX  = {SD_W{1'b1}};

    logic                    sparse_reg;
    logic [CNT_W-1:0]        rows_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [CNT_W-1:0]        cnt_reg;

    logic signed [SUM_W-1:0] snap_s_reg;
    logic [SQ_W-1:0]         snap_q_reg;
    logic [CNT_W-1:0]        snap_n_reg;
    logic                    dflt_reg;

    logic [WIDE_W-1:0]       mcand_reg, prod_reg, a_reg, b_reg;
    logic [SUM_W-1:0]        mplier_reg;
    logic [DVS_W-1:0]        d_reg;
    logic [SUM_W-1:0]        mean_mag_reg;
    logic [WIDE_W-1:0]       dvd_reg;
    logic [DVS_W-1:0]        dvs_reg, rem_reg;
    logic [SQ_W-1:0]         sx_reg;
    logic [ROOT_W+1:0]       srem_reg;
    logic [ROOT_W-1:0]       root_reg;

    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;
    logic                    m_tuser_reg;

    // accumulate path
    logic                    take;
    logic signed [2*VAL_W-1:0] vsq;
    logic signed [SUM_W-1:0] sum_new;
    logic [SQ_W-1:0]         sq_new;
    logic [CNT_W-1:0]        cnt_new;
    logic [CNT_W-1:0]        rows_clamped, n_sel;
    logic                    binary;
    logic [SUM_W-1:0]        mag;

    assign take    = (sparse_reg || !is_missing) && (cnt_reg < MAX_N);
    assign vsq     = sample_value * sample_value;
    assign sum_new = take ? sum_reg + SUM_W'(sample_value) : sum_reg;
    assign sq_new  = take ? sq_reg + SQ_W'(unsigned'(vsq)) : sq_reg;
    assign cnt_new = take ? cnt_reg + 1'b1 : cnt_reg;

    always_comb begin
        rows_clamped = rows_reg;
        if (rows_reg < CNT_W'(2))
            rows_clamped = CNT_W'(2);
        if (rows_reg > MAX_N)
            rows_clamped = MAX_N;
    end

    assign n_sel  = sparse_reg ? rows_clamped : cnt_new;
    assign binary = !sum_new[SUM_W-1] &&
                    (sq_new == (SQ_W'(unsigned'(sum_new)) << FRAC_BITS));
    assign mag    = snap_s_reg[SUM_W-1] ? SUM_W'(-snap_s_reg) : SUM_W'(snap_s_reg);

    // divider and square root step logic
    logic [DVS_W:0]    dtmp;
    logic              dge;
    logic [ROOT_W+1:0] stmp, strial;
    logic              sge;

    assign dtmp   = {rem_reg, dvd_reg[WIDE_W-1]};
    assign dge    = dtmp >= {1'b0, dvs_reg};
    assign stmp   = {srem_reg[ROOT_W-1:0], sx_reg[SQ_W-1:SQ_W-2]};
    assign strial = {root_reg, 2'b01};
    assign sge    = stmp >= strial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sparse_reg <= 1'b0;
            rows_reg   <= CNT_W'(2);
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SPARSE_MODE: sparse_reg <= cfg_data[0];
                REG_ROW_COUNT:   rows_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            sq_reg  <= '0;
            cnt_reg <= '0;
        end else if (cmd.accept) begin
            if (last_in_column) begin
                sum_reg <= '0;
                sq_reg  <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_new;
                sq_reg  <= sq_new;
                cnt_reg <= cnt_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && last_in_column) begin
            snap_s_reg <= sum_new;
            snap_q_reg <= sq_new;
            snap_n_reg <= n_sel;
            dflt_reg   <= binary || (n_sel < CNT_W'(2));
        end
    end

    // shared shift-add multiplier, restoring divider, digit square root
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            case (cmd.op)
                OP_MUL_A: begin
                    mcand_reg  <= WIDE_W'(snap_q_reg);
                    mplier_reg <= SUM_W'(snap_n_reg);
                    prod_reg   <= '0;
                end
                OP_MUL_B: begin
                    a_reg      <= prod_reg;
                    mcand_reg  <= WIDE_W'(mag);
                    mplier_reg <= mag;
                    prod_reg   <= '0;
                end
                OP_MUL_D: begin
                    b_reg      <= prod_reg;
                    mcand_reg  <= WIDE_W'(snap_n_reg);
                    mplier_reg <= SUM_W'(snap_n_reg - 1'b1);
                    prod_reg   <= '0;
                end
                OP_DIV_MEAN: begin
                    d_reg   <= prod_reg[DVS_W-1:0];
                    dvd_reg <= WIDE_W'(mag);
                    dvs_reg <= DVS_W'(snap_n_reg);
                    rem_reg <= '0;
                end
                OP_DIV_VAR: begin
                    mean_mag_reg <= dvd_reg[SUM_W-1:0];
                    dvd_reg      <= (a_reg > b_reg) ? a_reg - b_reg : '0;
                    dvs_reg      <= d_reg;
                    rem_reg      <= '0;
                end
                OP_SQRT: begin
                    // quotient above 64 bits saturates
                    sx_reg   <= (dvd_reg[WIDE_W-1:SQ_W] != '0) ? {SQ_W{1'b1}}
                                                              : dvd_reg[SQ_W-1:0];
                    srem_reg <= '0;
                    root_reg <= '0;
                end
                default: ;
            endcase
        end else if (cmd.step) begin
            case (cmd.op)
                OP_MUL_A, OP_MUL_B, OP_MUL_D: begin
                    if (mplier_reg[0])
                        prod_reg <= prod_reg + mcand_reg;
                    mcand_reg  <= {mcand_reg[WIDE_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[SUM_W-1:1]};
                end
                OP_DIV_MEAN, OP_DIV_VAR: begin
                    rem_reg <= dge ? DVS_W'(dtmp - {1'b0, dvs_reg}) : dtmp[DVS_W-1:0];
                    dvd_reg <= {dvd_reg[WIDE_W-2:0], dge};
                end
                OP_SQRT: begin
                    srem_reg <= sge ? stmp - strial : stmp;
                    root_reg <= {root_reg[ROOT_W-2:0], sge};
                    sx_reg   <= {sx_reg[SQ_W-3:0], 2'b00};
                end
                default: ;
            endcase
        end
    end

    // result formatting
    logic [SD_W-1:0]         sd_sat;
    logic signed [VAL_W-1:0] mean_sat;
    logic                    dflt_out;

    assign sd_sat   = (root_reg > ROOT_W'(SD_MAX)) ? SD_MAX : root_reg[SD_W-1:0];
    assign dflt_out = dflt_reg || (sd_sat == '0);

    always_comb begin
        if (snap_s_reg[SUM_W-1]) begin
            if (mean_mag_reg > SUM_W'(24'h800000))
                mean_sat = VAL_W'(24'h800000);
            else
                mean_sat = VAL_W'(-mean_mag_reg[VAL_W-1:0]);
        end else begin
            if (mean_mag_reg > SUM_W'(24'h7FFFFF))
                mean_sat = VAL_W'(24'h7FFFFF);
            else
                mean_sat = mean_mag_reg[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {1'b0, (dflt_out ? SD_ONE : sd_sat),
                            (dflt_out ? VAL_W'(0) : mean_sat)};
            m_tuser_reg <= dflt_out;
        end
    end

    assign status.out_busy  = m_tvalid_reg && !m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- design/column_scale_statistics.sv -----
// channel  dir  handshake           payload
// s_       in   s_tvalid/s_tready   tdata: sample_value; tuser: is_missing; tlast
// m_       out  m_tvalid/m_tready   tdata: column_mean, column_sd; tuser: defaulted
// cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Items that do not close a column are taken back to back.
// A closing item starts the work in one shared shift-add multiplier, a
// restoring divider and a digit square root; no input is taken
// meanwhile. The result waits in an output register; the next column
// streams in while it is held. Reset (aresetn low, synchronous) clears
// the sums, the count, the configuration, the state and the output valid.
module column_scale_statistics import css_pkg::*; #(
    parameter int MAX_ROWS  = DEF_MAX_ROWS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [23:0]        s_tdata,    // [23:0] sample_value
    input  logic               s_tuser,    // [0] is_missing
    input  logic               s_tlast,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,    // [23:0] column_mean, [46:24] column_sd
    output logic               m_tuser,    // [0] defaulted
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [IDX_W-1:0]   cfg_index,
    input  logic [CNT_W-1:0]   cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    css_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    css_dpath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .sample_value   (signed'(s_tdata)),
        .is_missing     (s_tuser),
        .last_in_column (s_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule
